>>> hdl/median_filter_3x3_rgb_macros.svh
// assertion macros for the 3x3 rgb median filter
`ifndef MEDIAN_FILTER_3X3_RGB_MACROS_SVH
`define MEDIAN_FILTER_3X3_RGB_MACROS_SVH
`ifndef SYNTH
`define MF3_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mf3 assertion failed");
`define MF3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mf3 assertion failed");
`else
`define MF3_ASSERT(lbl, prop)
`define MF3_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> hdl/mf3_pkg.sv
// types, constants and sorting network stages for the 3x3 rgb median filter
package mf3_pkg;

  localparam int CHANNEL_BITS     = 8;
  localparam int PIX_BITS         = 3 * CHANNEL_BITS;
  localparam int WIN_DIM          = 3;
  localparam int WIN_TAPS         = WIN_DIM * WIN_DIM;
  localparam int MEDIAN_TAP       = 4;
  localparam int MAX_HEIGHT       = 2048;
  localparam int CFG_BITS         = 12;
  localparam int CFG_IDX_BITS     = 1;
  localparam int ROW_BITS         = 11;
  localparam int QDEPTH           = 4;
  localparam int QPTR_BITS        = 2;
  localparam int QFILL_BITS       = 3;
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [CHANNEL_BITS-1:0] chan_t;
  typedef logic [PIX_BITS-1:0]     pix_t;
  typedef chan_t [WIN_TAPS-1:0]    chan_vec_t;
  typedef chan_vec_t [2:0]         rgb_vec_t;
  typedef pix_t [WIN_TAPS-1:0]     win_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } edge_mask_t;

  typedef struct packed {
    pix_t       pix;
    logic       has_out;
    logic       last;
    edge_mask_t off;
  } front_cmd_t;

  typedef struct packed {
    win_t win;
    logic last;
  } win_entry_t;

  // compare-exchange, smaller value ends at index a
  function automatic chan_vec_t cx(chan_vec_t v, int unsigned a, int unsigned b);
    chan_vec_t r;
    r = v;
    if (v[a] > v[b]) begin
      r[a] = v[b];
      r[b] = v[a];
    end
    return r;
  endfunction

  function automatic chan_vec_t sort_s1(chan_vec_t v);
    chan_vec_t r;
    r = cx(v, 1, 2);
    r = cx(r, 4, 5);
    r = cx(r, 7, 8);
    r = cx(r, 0, 1);
    r = cx(r, 3, 4);
    r = cx(r, 6, 7);
    r = cx(r, 1, 2);
    r = cx(r, 4, 5);
    r = cx(r, 7, 8);
    return r;
  endfunction

  function automatic chan_vec_t sort_s2(chan_vec_t v);
    chan_vec_t r;
    r = cx(v, 0, 3);
    r = cx(r, 5, 8);
    r = cx(r, 4, 7);
    r = cx(r, 3, 6);
    r = cx(r, 1, 4);
    r = cx(r, 2, 5);
    r = cx(r, 4, 7);
    return r;
  endfunction

  function automatic chan_vec_t sort_s3(chan_vec_t v);
    chan_vec_t r;
    r = cx(v, 4, 2);
    r = cx(r, 6, 4);
    r = cx(r, 4, 2);
    return r;
  endfunction

  // channel 0 red, 1 green, 2 blue
  function automatic rgb_vec_t split_rgb(win_t w);
    rgb_vec_t r;
    for (int i = 0; i < WIN_TAPS; i++) begin
      r[0][i] = w[i][2*CHANNEL_BITS +: CHANNEL_BITS];
      r[1][i] = w[i][CHANNEL_BITS +: CHANNEL_BITS];
      r[2][i] = w[i][0 +: CHANNEL_BITS];
    end
    return r;
  endfunction

endpackage

>>> hdl/mf3_front.sv
// front end: frame registers, position counters and item classification
module mf3_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [mf3_pkg::CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [mf3_pkg::CFG_BITS-1:0]           cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic                                   req_type_i,
  input  logic [mf3_pkg::CHANNEL_BITS-1:0]       red_in_i,
  input  logic [mf3_pkg::CHANNEL_BITS-1:0]       green_in_i,
  input  logic [mf3_pkg::CHANNEL_BITS-1:0]       blue_in_i,
  input  logic [mf3_pkg::QFILL_BITS-1:0]         q_fill_i,
  input  logic                                   s1_push_i,
  output logic                                   cmd_valid_o,
  output mf3_pkg::front_cmd_t                    cmd_o,
  output logic [$clog2(MAX_WIDTH)-1:0]           addr_o
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int TW    = WW + mf3_pkg::CFG_BITS;
  localparam int PW    = TW + 1;
  localparam int RST_W = (mf3_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH
                                                               : mf3_pkg::FRAME_WIDTH_RST;
  localparam int RST_H = mf3_pkg::FRAME_HEIGHT_RST;

  logic [WW-1:0]                    w_q;
  logic [CW-1:0]                    wm1_q;
  logic [mf3_pkg::CFG_BITS-1:0]     h_q;
  logic [mf3_pkg::ROW_BITS-1:0]     hm1_q;
  logic [TW-1:0]                    total_q;
  logic [CW-1:0]                    col_q;
  logic [PW-1:0]                    p_q;
  logic [CW-1:0]                    ocol_q;
  logic [mf3_pkg::ROW_BITS-1:0]     orow_q;

  logic [WW-1:0]                    new_w;
  logic [mf3_pkg::CFG_BITS-1:0]     new_h;
  logic [WW-1:0]                    op_w;
  logic [mf3_pkg::CFG_BITS-1:0]     op_h;
  logic [TW-1:0]                    total_prod;
  logic [mf3_pkg::QFILL_BITS:0]     credit_used;
  logic                             accept;
  logic                             in_frame;
  logic                             ignore_item;
  logic                             has_out;
  logic                             last;

  // clamp written sizes
  always_comb begin
    if (cfg_data_i == '0) begin
      new_w = WW'(1);
    end else if (int'(cfg_data_i) > MAX_WIDTH) begin
      new_w = WW'(MAX_WIDTH);
    end else begin
      new_w = WW'(cfg_data_i);
    end
    if (cfg_data_i == '0) begin
      new_h = mf3_pkg::CFG_BITS'(1);
    end else if (int'(cfg_data_i) > mf3_pkg::MAX_HEIGHT) begin
      new_h = mf3_pkg::CFG_BITS'(mf3_pkg::MAX_HEIGHT);
    end else begin
      new_h = cfg_data_i;
    end
    op_w = w_q;
    op_h = h_q;
    case (mf3_pkg::cfg_reg_e'(cfg_idx_i))
      mf3_pkg::REG_FRAME_WIDTH:  op_w = new_w;
      mf3_pkg::REG_FRAME_HEIGHT: op_h = new_h;
      default: ;
    endcase
    total_prod = {{mf3_pkg::CFG_BITS{1'b0}}, op_w} * {{WW{1'b0}}, op_h};
  end

  always_comb begin
    credit_used = {1'b0, q_fill_i} + {{mf3_pkg::QFILL_BITS{1'b0}}, s1_push_i};
    in_ready_o  = credit_used < (mf3_pkg::QFILL_BITS + 1)'(mf3_pkg::QDEPTH);
    accept      = in_valid_i && in_ready_o;
    in_frame    = p_q < PW'(total_q);
    ignore_item = req_type_i && in_frame;
    has_out     = p_q > PW'(w_q);
    last        = has_out && (orow_q == hm1_q) && (ocol_q == wm1_q);
    cmd_valid_o = accept && !ignore_item;
    cmd_o.pix   = (in_frame && !req_type_i) ? {red_in_i, green_in_i, blue_in_i} : '0;
    cmd_o.has_out    = has_out;
    cmd_o.last       = last;
    cmd_o.off.top    = (orow_q == '0);
    cmd_o.off.bottom = (orow_q == hm1_q);
    cmd_o.off.left   = (ocol_q == '0);
    cmd_o.off.right  = (ocol_q == wm1_q);
    addr_o      = col_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q     <= WW'(RST_W);
      wm1_q   <= CW'(RST_W - 1);
      h_q     <= mf3_pkg::CFG_BITS'(RST_H);
      hm1_q   <= mf3_pkg::ROW_BITS'(RST_H - 1);
      total_q <= TW'(RST_W * RST_H);
      col_q   <= '0;
      p_q     <= '0;
      ocol_q  <= '0;
      orow_q  <= '0;
    end else if (cfg_we_i) begin
      case (mf3_pkg::cfg_reg_e'(cfg_idx_i))
        mf3_pkg::REG_FRAME_WIDTH: begin
          w_q   <= new_w;
          wm1_q <= CW'(new_w - WW'(1));
        end
        mf3_pkg::REG_FRAME_HEIGHT: begin
          h_q   <= new_h;
          hm1_q <= mf3_pkg::ROW_BITS'(new_h - mf3_pkg::CFG_BITS'(1));
        end
        default: ;
      endcase
      total_q <= total_prod;
      col_q   <= '0;
      p_q     <= '0;
      ocol_q  <= '0;
      orow_q  <= '0;
    end else if (cmd_valid_o) begin
      if (last) begin
        col_q  <= '0;
        p_q    <= '0;
        ocol_q <= '0;
        orow_q <= '0;
      end else begin
        col_q <= (col_q == wm1_q) ? '0 : col_q + CW'(1);
        p_q   <= p_q + PW'(1);
        if (has_out) begin
          if (ocol_q == wm1_q) begin
            ocol_q <= '0;
            orow_q <= orow_q + mf3_pkg::ROW_BITS'(1);
          end else begin
            ocol_q <= ocol_q + CW'(1);
          end
        end
      end
    end
  end

endmodule

>>> hdl/mf3_window.sv
// line store and 3x3 window, builds the masked neighbourhood of each item
module mf3_window #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  mf3_pkg::front_cmd_t            cmd_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]   addr_i,
  output logic                           push_o,
  output mf3_pkg::win_entry_t            entry_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = 2 * mf3_pkg::PIX_BITS;

  // upper half is the row two above, lower half the row above
  logic [LW-1:0]          line_mem_q [MAX_WIDTH];
  logic [LW-1:0]          rd_q;
  logic                   fwd_q;
  logic [LW-1:0]          fwd_data_q;
  logic                   s1_valid_q;
  mf3_pkg::front_cmd_t    s1_cmd_q;
  logic [CW-1:0]          s1_addr_q;
  mf3_pkg::win_t          win_q;

  logic [LW-1:0]          rd_data;
  mf3_pkg::pix_t          top;
  mf3_pkg::pix_t          mid;
  logic [LW-1:0]          wr_data;
  mf3_pkg::win_t          win_d;

  always_comb begin
    logic off;
    rd_data = fwd_q ? fwd_data_q : rd_q;
    top     = rd_data[LW-1:mf3_pkg::PIX_BITS];
    mid     = rd_data[mf3_pkg::PIX_BITS-1:0];
    wr_data = {mid, s1_cmd_q.pix};
    for (int r = 0; r < mf3_pkg::WIN_DIM; r++) begin
      for (int q = 0; q < mf3_pkg::WIN_DIM - 1; q++) begin
        win_d[r*mf3_pkg::WIN_DIM + q] = win_q[r*mf3_pkg::WIN_DIM + q + 1];
      end
    end
    win_d[mf3_pkg::WIN_DIM - 1]       = top;
    win_d[2*mf3_pkg::WIN_DIM - 1]     = mid;
    win_d[mf3_pkg::WIN_TAPS - 1]      = s1_cmd_q.pix;
    for (int r = 0; r < mf3_pkg::WIN_DIM; r++) begin
      for (int q = 0; q < mf3_pkg::WIN_DIM; q++) begin
        off = (r == 0 && s1_cmd_q.off.top) ||
              (r == mf3_pkg::WIN_DIM - 1 && s1_cmd_q.off.bottom) ||
              (q == 0 && s1_cmd_q.off.left) ||
              (q == mf3_pkg::WIN_DIM - 1 && s1_cmd_q.off.right);
        entry_o.win[r*mf3_pkg::WIN_DIM + q] = off ? '0 : win_d[r*mf3_pkg::WIN_DIM + q];
      end
    end
    entry_o.last = s1_cmd_q.last;
    push_o       = s1_valid_q && s1_cmd_q.has_out;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i) begin
      rd_q <= line_mem_q[addr_i];
    end
    if (s1_valid_q) begin
      line_mem_q[s1_addr_q] <= wr_data;
    end
  end

  // same column back to back: take the value still being written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q      <= 1'b0;
      s1_valid_q <= 1'b0;
      win_q      <= '0;
    end else begin
      fwd_q      <= cmd_valid_i && s1_valid_q && (addr_i == s1_addr_q);
      s1_valid_q <= cmd_valid_i;
      if (s1_valid_q) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wr_data;
    if (cmd_valid_i) begin
      s1_cmd_q  <= cmd_i;
      s1_addr_q <= addr_i;
    end
  end

endmodule

>>> hdl/mf3_queue.sv
// short queue of neighbourhoods between the window and the median stages
module mf3_queue (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  mf3_pkg::win_entry_t               entry_i,
  input  logic                              pop_i,
  output mf3_pkg::win_entry_t               head_o,
  output logic                              nonempty_o,
  output logic [mf3_pkg::QFILL_BITS-1:0]    fill_o
);

  mf3_pkg::win_entry_t                entries_q [mf3_pkg::QDEPTH];
  logic [mf3_pkg::QPTR_BITS-1:0]      wr_ptr_q;
  logic [mf3_pkg::QPTR_BITS-1:0]      rd_ptr_q;
  logic [mf3_pkg::QFILL_BITS-1:0]     fill_q;
  logic [mf3_pkg::QFILL_BITS-1:0]     fill_d;

  always_comb begin
    fill_d = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + mf3_pkg::QFILL_BITS'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - mf3_pkg::QFILL_BITS'(1);
    end
    head_o     = entries_q[rd_ptr_q];
    nonempty_o = (fill_q != '0);
    fill_o     = fill_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + mf3_pkg::QPTR_BITS'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + mf3_pkg::QPTR_BITS'(1);
      end
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

>>> hdl/mf3_back.sv
// back end: three-stage median network per channel and output register
module mf3_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mf3_pkg::win_entry_t                 head_i,
  input  logic                                nonempty_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mf3_pkg::CHANNEL_BITS-1:0]    red_med_o,
  output logic [mf3_pkg::CHANNEL_BITS-1:0]    green_med_o,
  output logic [mf3_pkg::CHANNEL_BITS-1:0]    blue_med_o,
  output logic                                frame_last_o
);

  logic                 va_q;
  logic                 vb_q;
  logic                 out_valid_q;
  mf3_pkg::rgb_vec_t    a_q;
  mf3_pkg::rgb_vec_t    b_q;
  logic                 la_q;
  logic                 lb_q;
  logic                 last_q;
  mf3_pkg::chan_t       red_q;
  mf3_pkg::chan_t       green_q;
  mf3_pkg::chan_t       blue_q;

  logic                 en;
  mf3_pkg::rgb_vec_t    split;
  mf3_pkg::rgb_vec_t    a_d;
  mf3_pkg::rgb_vec_t    b_d;
  mf3_pkg::rgb_vec_t    c_d;

  always_comb begin
    en    = !out_valid_q || out_ready_i;
    pop_o = en && nonempty_i;
    split = mf3_pkg::split_rgb(head_i.win);
    for (int c = 0; c < 3; c++) begin
      a_d[c] = mf3_pkg::sort_s1(split[c]);
      b_d[c] = mf3_pkg::sort_s2(a_q[c]);
      c_d[c] = mf3_pkg::sort_s3(b_q[c]);
    end
    out_valid_o  = out_valid_q;
    red_med_o    = red_q;
    green_med_o  = green_q;
    blue_med_o   = blue_q;
    frame_last_o = last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      va_q        <= nonempty_i;
      vb_q        <= va_q;
      out_valid_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q     <= a_d;
      la_q    <= head_i.last;
      b_q     <= b_d;
      lb_q    <= la_q;
      red_q   <= c_d[0][mf3_pkg::MEDIAN_TAP];
      green_q <= c_d[1][mf3_pkg::MEDIAN_TAP];
      blue_q  <= c_d[2][mf3_pkg::MEDIAN_TAP];
      last_q  <= lb_q;
    end
  end

endmodule

>>> hdl/median_filter_3x3_rgb.sv
// top level of the streaming 3x3 rgb median filter
// throughput: one item per cycle while in_ready is high, results one per cycle while the output is taken
// registers from the item that completes a neighbourhood to its result:
//   line store read, queue write, two sorting network stages, output register
// reset: asynchronous active low; clears counters, window, queue and valids,
//   frame size returns to 640x480, the line store is not cleared
module median_filter_3x3_rgb #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mf3_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [mf3_pkg::CFG_BITS-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic [mf3_pkg::CHANNEL_BITS-1:0]    red_in_i,
  input  logic [mf3_pkg::CHANNEL_BITS-1:0]    green_in_i,
  input  logic [mf3_pkg::CHANNEL_BITS-1:0]    blue_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [mf3_pkg::CHANNEL_BITS-1:0]    red_med_o,
  output logic [mf3_pkg::CHANNEL_BITS-1:0]    green_med_o,
  output logic [mf3_pkg::CHANNEL_BITS-1:0]    blue_med_o,
  output logic                                frame_last_o
);

  logic                                 cmd_valid;
  mf3_pkg::front_cmd_t                  cmd;
  logic [$clog2(MAX_WIDTH)-1:0]         addr;
  logic                                 push;
  mf3_pkg::win_entry_t                  entry;
  mf3_pkg::win_entry_t                  head;
  logic                                 q_nonempty;
  logic [mf3_pkg::QFILL_BITS-1:0]       q_fill;
  logic                                 q_pop;
  logic [mf3_pkg::QFILL_BITS:0]         credit_used;

  mf3_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .q_fill_i    (q_fill),
    .s1_push_i   (push),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .addr_o      (addr)
  );

  mf3_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .addr_i      (addr),
    .push_o      (push),
    .entry_o     (entry)
  );

  mf3_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .entry_i    (entry),
    .pop_i      (q_pop),
    .head_o     (head),
    .nonempty_o (q_nonempty),
    .fill_o     (q_fill)
  );

  mf3_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .nonempty_i   (q_nonempty),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_med_o    (red_med_o),
    .green_med_o  (green_med_o),
    .blue_med_o   (blue_med_o),
    .frame_last_o (frame_last_o)
  );

  assign credit_used = {1'b0, q_fill} + {{mf3_pkg::QFILL_BITS{1'b0}}, push};

`include "median_filter_3x3_rgb_macros.svh"

  `MF3_ASSERT(a_credit_bound, credit_used <= (mf3_pkg::QFILL_BITS + 1)'(mf3_pkg::QDEPTH))
  `MF3_ASSERT(a_pop_nonempty, q_pop |-> q_nonempty)
  `MF3_ASSERT(a_last_has_out, cmd_valid && cmd.last |-> cmd.has_out)
  `MF3_ASSERT_NEXT(a_push_follows_cmd, cmd_valid && cmd.has_out, push)

endmodule

>>> sim/median_filter_3x3_rgb_tb.sv
// self-checking bench for the 3x3 rgb median filter against an in-bench predictor
module median_filter_3x3_rgb_tb;
  import mf3_pkg::*;

  localparam int unsigned MAX_COLS     = 2048;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE_TICKS = 16;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned EXTREME_STEPS = 40;
  localparam logic        REQ_PIXEL    = 1'b0;
  localparam logic        REQ_PAD      = 1'b1;

  typedef struct packed {
    logic  pad;
    chan_t red;
    chan_t green;
    chan_t blue;
  } px_req_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  last;
  } med_px_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx = REG_FRAME_WIDTH;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                req_type = REQ_PIXEL;
  chan_t               red_in = '0;
  chan_t               green_in = '0;
  chan_t               blue_in = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  chan_t               red_med;
  chan_t               green_med;
  chan_t               blue_med;
  logic                frame_last;

  median_filter_3x3_rgb #(
    .MAX_WIDTH(MAX_COLS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .req_type_i   (req_type),
    .red_in_i     (red_in),
    .green_in_i   (green_in),
    .blue_in_i    (blue_in),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .red_med_o    (red_med),
    .green_med_o  (green_med),
    .blue_med_o   (blue_med),
    .frame_last_o (frame_last)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // filter state as the block should hold it
  pix_t        line_a [MAX_COLS] = '{default: '0};
  pix_t        line_b [MAX_COLS] = '{default: '0};
  pix_t        win_q [WIN_TAPS] = '{default: '0};
  int unsigned col_q = 0;
  int unsigned row_q = 0;
  int unsigned outs_q = 0;
  int unsigned width_reg = FRAME_WIDTH_RST;
  int unsigned height_reg = FRAME_HEIGHT_RST;

  px_req_t     px_pending [$];
  med_px_t     medians_due [$];
  med_px_t     seen_px;
  med_px_t     want_px;
  px_req_t     drv_item;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  int unsigned hold_left = 0;

  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned items_taken = 0;
  int unsigned pads_ignored = 0;
  int unsigned medians_seen = 0;
  int unsigned frames_done = 0;
  int unsigned reg_writes = 0;
  int unsigned useful_items = 0;

  function automatic int unsigned eff_dim(input int unsigned v, input int unsigned cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  function automatic chan_t fifth_largest(input chan_vec_t v);
    chan_vec_t s;
    chan_t     t;
    int        j;
    s = v;
    for (int i = 1; i < WIN_TAPS; i++) begin
      t = s[i];
      j = i;
      while (j > 0 && s[j-1] < t) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = t;
    end
    return s[MEDIAN_TAP];
  endfunction

  function automatic void filter_step(input logic pad, input chan_t r_in, input chan_t g_in,
                                      input chan_t b_in);
    int unsigned w, h, total, p, c, k, orow, ocol;
    pix_t        px, top, mid, v;
    chan_vec_t   red_v, grn_v, blu_v;
    logic        off;
    med_px_t     res;
    w = eff_dim(width_reg, MAX_COLS);
    h = eff_dim(height_reg, MAX_HEIGHT);
    total = w * h;
    if (col_q >= w) col_q = 0;
    p = row_q * w + col_q;
    if (pad == REQ_PAD && p < total) begin
      pads_ignored++;
      return;
    end
    px = (pad == REQ_PIXEL && p < total) ? {r_in, g_in, b_in} : '0;
    c = col_q;
    top = line_b[c];
    mid = line_a[c];
    line_b[c] = mid;
    line_a[c] = px;
    for (int r = 0; r < 3; r++) begin
      win_q[r*3]   = win_q[r*3+1];
      win_q[r*3+1] = win_q[r*3+2];
    end
    win_q[2] = top;
    win_q[5] = mid;
    win_q[8] = px;
    col_q++;
    if (col_q >= w) begin
      col_q = 0;
      row_q++;
    end
    if (p < w + 1) return;
    k = outs_q;
    orow = k / w;
    ocol = k % w;
    for (int r = 0; r < 3; r++) begin
      for (int q = 0; q < 3; q++) begin
        v = win_q[r*3+q];
        off = (r == 0 && orow == 0) || (r == 2 && orow + 1 >= h) ||
              (q == 0 && ocol == 0) || (q == 2 && ocol + 1 >= w);
        if (off) v = '0;
        red_v[r*3+q] = v[23:16];
        grn_v[r*3+q] = v[15:8];
        blu_v[r*3+q] = v[7:0];
      end
    end
    res.red   = fifth_largest(red_v);
    res.green = fifth_largest(grn_v);
    res.blue  = fifth_largest(blu_v);
    res.last  = (k + 1 >= total);
    outs_q = k + 1;
    if (res.last) begin
      col_q = 0;
      row_q = 0;
      outs_q = 0;
    end
    medians_due.push_back(res);
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        filter_step(req_type, red_in, green_in, blue_in);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (px_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_item = px_pending.pop_front();
          req_type <= drv_item.pad;
          red_in   <= drv_item.red;
          green_in <= drv_item.green;
          blue_in  <= drv_item.blue;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        seen_px = '{red: red_med, green: green_med, blue: blue_med, last: frame_last};
        medians_seen++;
        if (seen_px.last === 1'b1) frames_done++;
        if (medians_due.size() == 0) begin
          if (err_cnt < 20)
            $display("%0t: unexpected item, got r %0d g %0d b %0d last %0b", $time,
                     seen_px.red, seen_px.green, seen_px.blue, seen_px.last);
          err_cnt++;
        end else begin
          want_px = medians_due.pop_front();
          if (want_px !== seen_px) begin
            if (err_cnt < 20)
              $display("%0t: mismatch, expected r %0d g %0d b %0d last %0b", $time,
                       want_px.red, want_px.green, want_px.blue, want_px.last,
                       ", got r %0d g %0d b %0d last %0b",
                       seen_px.red, seen_px.green, seen_px.blue, seen_px.last);
            err_cnt++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left  <= LONG_HOLD;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d items pending and %0d medians outstanding", $time,
               px_pending.size(), medians_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic chan_t rand_chan();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return chan_t'($urandom_range(255));
    endcase
  endfunction

  task automatic drain();
    while (px_pending.size() != 0 || in_valid || medians_due.size() != 0) @(negedge clk_i);
  endtask

  task automatic settle();
    drain();
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_BITS-1:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    if (idx == REG_FRAME_WIDTH) width_reg = val;
    else height_reg = val;
    col_q = 0;
    row_q = 0;
    outs_q = 0;
    reg_writes++;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // one frame of random pixels then its flushing tail, stopped after max_steps pixels and tail items
  task automatic queue_frame(input int unsigned w, input int unsigned h,
                             input int unsigned max_steps);
    int unsigned done;
    done = 0;
    for (int unsigned n = 0; n < w * h && done < max_steps; n++) begin
      if ($urandom_range(15) == 0)
        px_pending.push_back('{REQ_PAD, rand_chan(), rand_chan(), rand_chan()});
      px_pending.push_back('{REQ_PIXEL, rand_chan(), rand_chan(), rand_chan()});
      done++;
    end
    for (int unsigned n = 0; n <= w && done < max_steps; n++) begin
      if ($urandom_range(3) == 0)
        px_pending.push_back('{REQ_PIXEL, rand_chan(), rand_chan(), rand_chan()});
      else
        px_pending.push_back('{REQ_PAD, rand_chan(), rand_chan(), rand_chan()});
      done++;
    end
    useful_items += done;
  endtask

  initial begin
    int unsigned w, h, nframes, ew, eh, pick;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 10;
    recv_idle_pct = 78;

    // directed 3x3 frame: extremes, padding inside the frame, pixel in the tail
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 3);
    px_pending.push_back('{REQ_PIXEL, 8'd255, 8'd255, 8'd255});
    px_pending.push_back('{REQ_PIXEL, 8'd0, 8'd0, 8'd0});
    px_pending.push_back('{REQ_PIXEL, 8'd255, 8'd0, 8'd255});
    px_pending.push_back('{REQ_PAD, 8'd17, 8'd34, 8'd51});
    px_pending.push_back('{REQ_PIXEL, 8'd0, 8'd255, 8'd0});
    px_pending.push_back('{REQ_PIXEL, 8'd128, 8'd127, 8'd1});
    px_pending.push_back('{REQ_PIXEL, 8'd254, 8'd1, 8'd128});
    px_pending.push_back('{REQ_PIXEL, 8'd7, 8'd200, 8'd99});
    px_pending.push_back('{REQ_PIXEL, 8'd255, 8'd255, 8'd0});
    px_pending.push_back('{REQ_PIXEL, 8'd0, 8'd0, 8'd255});
    px_pending.push_back('{REQ_PIXEL, 8'd9, 8'd9, 8'd9});
    px_pending.push_back('{REQ_PAD, 8'd0, 8'd0, 8'd0});
    px_pending.push_back('{REQ_PAD, 8'd255, 8'd255, 8'd255});
    px_pending.push_back('{REQ_PAD, 8'd0, 8'd0, 8'd0});
    settle();

    // zero sizes act as a single pixel frame
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 0);
    px_pending.push_back('{REQ_PIXEL, 8'd255, 8'd128, 8'd0});
    px_pending.push_back('{REQ_PIXEL, 8'd1, 8'd2, 8'd3});
    px_pending.push_back('{REQ_PAD, 8'd0, 8'd0, 8'd0});

    for (int unsigned stage = 0; stage < 3; stage++) begin
      settle();
      send_idle_pct = (stage == 0) ? 10 : (stage == 1) ? 78 : 0;
      recv_idle_pct = (stage == 0) ? 78 : (stage == 1) ? 10 : 0;
      if (stage == 2) begin
        // long receiver hold while the sender keeps offering
        write_reg(REG_FRAME_WIDTH, 8);
        write_reg(REG_FRAME_HEIGHT, 6);
        hold_req = 1'b1;
        queue_frame(8, 6, '1);
      end
      while (useful_items < (stage + 1) * RANDOM_ITEMS / 3) begin
        settle();
        w = ($urandom_range(11) == 0) ? 0 : $urandom_range(1, 12);
        h = ($urandom_range(11) == 0) ? 0 : $urandom_range(1, 6);
        pick = $urandom_range(3);
        if (pick != 1) write_reg(REG_FRAME_WIDTH, w);
        if (pick != 0) write_reg(REG_FRAME_HEIGHT, h);
        ew = eff_dim(width_reg, MAX_COLS);
        eh = eff_dim(height_reg, MAX_HEIGHT);
        nframes = $urandom_range(1, 3);
        for (int unsigned f = 0; f < nframes; f++) begin
          if ($urandom_range(9) == 0) begin
            // abandoned frame, the next register write restarts it
            queue_frame(ew, eh, $urandom_range(ew * eh + ew));
            break;
          end
          queue_frame(ew, eh, '1);
          if ($urandom_range(4) == 0) drain();
        end
      end
    end

    // widest row, cut short before its first median
    settle();
    write_reg(REG_FRAME_WIDTH, '1);
    write_reg(REG_FRAME_HEIGHT, 1);
    queue_frame(MAX_COLS, 1, EXTREME_STEPS);
    settle();
    // tallest frame, cut short after its first rows
    write_reg(REG_FRAME_WIDTH, 1);
    write_reg(REG_FRAME_HEIGHT, '1);
    queue_frame(1, MAX_HEIGHT, EXTREME_STEPS);

    drain();
    repeat (SETTLE_TICKS) @(negedge clk_i);
    $display("run covered %0d items (%0d padding ticks dropped inside frames), %0d writes",
             items_taken, pads_ignored, reg_writes);
    $display("checked %0d medians over %0d frames, from 1x1 up to clamped extreme sizes",
             medians_seen, frames_done);
    if (err_cnt == 0 && medians_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
